// ----- rtl/hds_pkg.sv -----
// Shared types, constants and fixed-point helpers of the diffusion stencil.
// Used by the top, hds_ctrl, hds_dp and the testbench; depends on nothing.
`default_nettype none
package hds_pkg;

	localparam int MAX_WIDTH = 512;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int LINE_AW   = COL_W + 1;
	localparam int GW_W      = 10;
	localparam int GH_W      = 16;

	localparam logic signed [63:0] FX_RND =
		(FRAC_BITS > 0) ? (64'sd1 <<< ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0)) : 64'sd0;
	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef enum logic [1:0] {
		REG_GRID_WIDTH  = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_TIME_STEP   = 2'd2
	} hds_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_WR_HELD,
		ST_WR_IN,
		ST_PREP,
		ST_MUL,
		ST_POST,
		ST_FINAL,
		ST_SHIFT
	} hds_state_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		SRC_Q_M,
		SRC_T_HS,
		SRC_T_SD,
		SRC_TS_PM,
		SRC_T_PN,
		SRC_T_DIV
	} hds_src_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] tracer_value;
		logic signed [DATA_W-1:0] diffusivity;
		logic signed [DATA_W-1:0] layer_thickness;
		logic signed [DATA_W-1:0] inv_dx;
		logic signed [DATA_W-1:0] inv_dy;
		logic signed [DATA_W-1:0] u_face_metric;
		logic signed [DATA_W-1:0] v_face_metric;
	} hds_cell_t;

	typedef struct packed {
		logic              we;
		logic [1:0]        index;
		logic [DATA_W-1:0] data;
	} hds_cfg_wr_t;

	typedef struct packed {
		logic             load;
		logic             rd;
		logic [1:0]       rd_sel;
		logic             cap;
		logic [1:0]       cap_sel;
		logic             wr_held;
		logic             wr_in;
		logic             prep;
		logic [1:0]       flux;
		logic             mul;
		hds_src_t         src;
		logic             post;
		logic             acc;
		logic             fin;
		logic             shift;
		logic [COL_W-1:0] col;
		logic             par;
		logic             done;
	} hds_cmd_t;

	typedef struct packed {
		logic out_busy;
	} hds_stat_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > S32_MAX) r = S32_MAX[DATA_W-1:0];
		else if (v < S32_MIN) r = S32_MIN[DATA_W-1:0];
		else r = v[DATA_W-1:0];
		return r;
	endfunction

	// round, floor-shift by the fraction width, saturate
	function automatic logic signed [DATA_W-1:0] fx_post(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + FX_RND) >>> FRAC_BITS;
		return sat32(r);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/hds_cell_if.sv -----
// Input channel of the stencil: one grid cell per request.
// Depends on nothing.
`default_nettype none
interface hds_cell_if;
	logic        valid;
	logic        ready;
	logic [31:0] tracer_value;
	logic [31:0] diffusivity;
	logic [31:0] layer_thickness;
	logic [31:0] inv_dx;
	logic [31:0] inv_dy;
	logic [31:0] u_face_metric;
	logic [31:0] v_face_metric;
	modport source (output valid, tracer_value, diffusivity, layer_thickness, inv_dx,
		inv_dy, u_face_metric, v_face_metric, input ready);
	modport sink (input valid, tracer_value, diffusivity, layer_thickness, inv_dx,
		inv_dy, u_face_metric, v_face_metric, output ready);
endinterface
`default_nettype wire

// ----- rtl/hds_result_if.sv -----
// Output channel of the stencil: one diffused interior cell per request.
// Depends on nothing.
`default_nettype none
interface hds_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] updated_value;
	logic        plane_done;
	modport source (output valid, updated_value, plane_done, input ready);
	modport sink (input valid, updated_value, plane_done, output ready);
endinterface
`default_nettype wire

// ----- rtl/hds_cfg_if.sv -----
// Register write channel of the stencil.
// Depends on nothing.
`default_nettype none
interface hds_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [31:0] wr_data;
	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/harmonic_diffusion_stencil_top.sv -----
// Five-point harmonic diffusion stencil over a raster stream of cells with a
// one-cell halo. A cell request that releases an interior result passes through
// line-store reads, one or two line-store writes, then fifteen fixed-point
// products through one shared 32x32 multiplier. A result is held in an output
// register, so the next cell is taken while it waits; a second result waits
// until the first one is taken. Results lag one row and one cell behind the
// input. Depends on hds_pkg, the channel interfaces, hds_ctrl, hds_dp and hds_ram.
`default_nettype none
module harmonic_diffusion_stencil_top (
	input  wire logic clk,
	input  wire logic arst_n,
	hds_cell_if.sink     grid_cell,
	hds_result_if.source result,
	hds_cfg_if.sink      cfg
);
	hds_pkg::hds_cmd_t    cmd;
	hds_pkg::hds_stat_t   stat;
	hds_pkg::hds_cfg_wr_t cfg_wr;
	hds_pkg::hds_cell_t   cell_data;

	// registers take every write
	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid;
	assign cfg_wr.index = cfg.reg_index;
	assign cfg_wr.data  = cfg.wr_data;

	assign cell_data.tracer_value    = grid_cell.tracer_value;
	assign cell_data.diffusivity     = grid_cell.diffusivity;
	assign cell_data.layer_thickness = grid_cell.layer_thickness;
	assign cell_data.inv_dx          = grid_cell.inv_dx;
	assign cell_data.inv_dy          = grid_cell.inv_dy;
	assign cell_data.u_face_metric   = grid_cell.u_face_metric;
	assign cell_data.v_face_metric   = grid_cell.v_face_metric;

	hds_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cell_valid(grid_cell.valid), .cell_ready(grid_cell.ready),
		.cfg_wr(cfg_wr), .stat(stat), .cmd(cmd));

	hds_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.grid_cell(cell_data), .cfg_wr(cfg_wr), .cmd(cmd), .stat(stat),
		.res_valid(result.valid), .res_ready(result.ready),
		.res_value(result.updated_value), .res_done(result.plane_done));
endmodule
`default_nettype wire

// ----- rtl/hds_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module hds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/hds_ctrl.sv -----
// Sequencer of the stencil: raster counters, geometry registers, item state machine.
// Depends on hds_pkg.
`default_nettype none
module hds_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cell_valid,
	output      logic                cell_ready,
	input  wire hds_pkg::hds_cfg_wr_t cfg_wr,
	input  wire hds_pkg::hds_stat_t  stat,
	output      hds_pkg::hds_cmd_t   cmd
);
	hds_pkg::hds_state_t state_q, state_d;
	logic [hds_pkg::GW_W-1:0]  grid_width_q;
	logic [hds_pkg::GH_W-1:0]  grid_height_q;
	logic [hds_pkg::COL_W-1:0] col_q, col_item_q;
	logic [hds_pkg::GH_W-1:0]  row_q;
	logic                      par_q, last_q, compute_q, done_q;
	logic [2:0]                flux_q, flux_d;
	logic [1:0]                sub_q, sub_d;
	logic [2:0]                rc_q, rc_d;

	logic [hds_pkg::COL_W:0]   w_eff;
	logic [hds_pkg::GH_W-1:0]  h_eff;
	logic [hds_pkg::COL_W-1:0] c_eff;
	logic                      last_c, accept, geo_wr;

	// clamp geometry
	always_comb begin
		if (grid_width_q < hds_pkg::GW_W'(3)) w_eff = (hds_pkg::COL_W+1)'(3);
		else if (32'(grid_width_q) > hds_pkg::MAX_WIDTH)
			w_eff = (hds_pkg::COL_W+1)'(hds_pkg::MAX_WIDTH);
		else w_eff = (hds_pkg::COL_W+1)'(grid_width_q);
		h_eff = (grid_height_q < hds_pkg::GH_W'(3)) ? hds_pkg::GH_W'(3) : grid_height_q;
		c_eff = ({1'b0, col_q} >= w_eff) ? hds_pkg::COL_W'(w_eff - 1'b1) : col_q;
		last_c = ({1'b0, c_eff} == w_eff - 1'b1);
	end

	assign accept = cell_valid && cell_ready;
	assign geo_wr = cfg_wr.we && (cfg_wr.index == hds_pkg::REG_GRID_WIDTH ||
		cfg_wr.index == hds_pkg::REG_GRID_HEIGHT);

	// geometry registers and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hds_pkg::GW_W'(512);
			grid_height_q <= hds_pkg::GH_W'(512);
			col_q         <= '0;
			row_q         <= '0;
		end else begin
			if (cfg_wr.we && cfg_wr.index == hds_pkg::REG_GRID_WIDTH)
				grid_width_q <= cfg_wr.data[hds_pkg::GW_W-1:0];
			if (cfg_wr.we && cfg_wr.index == hds_pkg::REG_GRID_HEIGHT)
				grid_height_q <= cfg_wr.data[hds_pkg::GH_W-1:0];
			if (geo_wr) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (last_c) begin
					col_q <= '0;
					row_q <= ((17'(row_q) + 17'd1) >= 17'(h_eff)) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= c_eff + 1'b1;
				end
			end
		end
	end

	// latch what the item needs
	always_ff @(posedge clk) begin
		if (accept) begin
			col_item_q <= c_eff;
			par_q      <= row_q[0];
			last_q     <= last_c;
			compute_q  <= (row_q >= hds_pkg::GH_W'(2)) && (c_eff >= hds_pkg::COL_W'(2));
			done_q     <= (row_q == h_eff - 1'b1) && last_c;
		end
	end

	// state and step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hds_pkg::ST_IDLE;
			flux_q  <= '0;
			sub_q   <= '0;
			rc_q    <= '0;
		end else begin
			state_q <= state_d;
			flux_q  <= flux_d;
			sub_q   <= sub_d;
			rc_q    <= rc_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		flux_d      = flux_q;
		sub_d       = sub_q;
		rc_d        = rc_q;
		cell_ready  = 1'b0;
		cmd         = '0;
		cmd.src     = hds_pkg::SRC_Q_M;
		cmd.col     = col_item_q;
		cmd.par     = par_q;
		cmd.done    = done_q;
		cmd.flux    = flux_q[1:0];
		cmd.rd_sel  = rc_q[1:0];
		cmd.cap_sel = 2'(rc_q - 3'd1);
		unique case (state_q)
			hds_pkg::ST_IDLE: begin
				cell_ready = 1'b1;
				if (accept) begin
					cmd.load = 1'b1;
					flux_d   = '0;
					sub_d    = '0;
					rc_d     = '0;
					if ((row_q >= hds_pkg::GH_W'(2)) && (c_eff >= hds_pkg::COL_W'(2)))
						state_d = hds_pkg::ST_READ;
					else if (c_eff != '0) state_d = hds_pkg::ST_WR_HELD;
					else state_d = hds_pkg::ST_SHIFT;
				end
			end
			hds_pkg::ST_READ: begin
				cmd.rd  = (rc_q < 3'd4);
				cmd.cap = (rc_q != 3'd0);
				rc_d    = rc_q + 3'd1;
				if (rc_q == 3'd4) state_d = hds_pkg::ST_WR_HELD;
			end
			hds_pkg::ST_WR_HELD: begin
				cmd.wr_held = 1'b1;
				if (last_q) state_d = hds_pkg::ST_WR_IN;
				else state_d = compute_q ? hds_pkg::ST_PREP : hds_pkg::ST_SHIFT;
			end
			hds_pkg::ST_WR_IN: begin
				cmd.wr_in = 1'b1;
				state_d   = compute_q ? hds_pkg::ST_PREP : hds_pkg::ST_SHIFT;
			end
			hds_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = hds_pkg::ST_MUL;
			end
			hds_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				if (flux_q == 3'd4) begin
					unique case (sub_q)
						2'd0:    cmd.src = hds_pkg::SRC_TS_PM;
						2'd1:    cmd.src = hds_pkg::SRC_T_PN;
						default: cmd.src = hds_pkg::SRC_T_DIV;
					endcase
				end else begin
					unique case (sub_q)
						2'd0:    cmd.src = hds_pkg::SRC_Q_M;
						2'd1:    cmd.src = hds_pkg::SRC_T_HS;
						default: cmd.src = hds_pkg::SRC_T_SD;
					endcase
				end
				state_d = hds_pkg::ST_POST;
			end
			hds_pkg::ST_POST: begin
				cmd.post = 1'b1;
				cmd.acc  = (flux_q != 3'd4) && (sub_q == 2'd2);
				if (sub_q != 2'd2) begin
					sub_d   = sub_q + 2'd1;
					state_d = hds_pkg::ST_MUL;
				end else begin
					sub_d = '0;
					if (flux_q == 3'd4) begin
						state_d = hds_pkg::ST_FINAL;
					end else begin
						flux_d  = flux_q + 3'd1;
						state_d = (flux_q == 3'd3) ? hds_pkg::ST_MUL : hds_pkg::ST_PREP;
					end
				end
			end
			hds_pkg::ST_FINAL: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.fin = 1'b1;
					state_d = hds_pkg::ST_SHIFT;
				end
			end
			hds_pkg::ST_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = hds_pkg::ST_IDLE;
			end
			default: state_d = hds_pkg::ST_IDLE;
		endcase
	end

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !stat.out_busy) else $error("result issued over a held result");
	a_accept_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != hds_pkg::ST_IDLE) else $error("accepted cell not worked");
	a_flux_range: assert property (@(posedge clk) disable iff (!arst_n)
		flux_q <= 3'd4) else $error("flux step out of range");
endmodule
`default_nettype wire

// ----- rtl/hds_dp.sv -----
// Datapath of the stencil: line stores, neighbor registers, shared multiplier,
// flux accumulator and output register. Depends on hds_pkg and hds_ram.
`default_nettype none
module hds_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire hds_pkg::hds_cell_t   grid_cell,
	input  wire hds_pkg::hds_cfg_wr_t cfg_wr,
	input  wire hds_pkg::hds_cmd_t    cmd,
	output      hds_pkg::hds_stat_t   stat,
	output      logic                 res_valid,
	input  wire logic                 res_ready,
	output      logic [31:0]          res_value,
	output      logic                 res_done
);
	localparam int DW = hds_pkg::DATA_W;
	localparam int AW = hds_pkg::LINE_AW;
	localparam int CW = hds_pkg::COL_W;

	logic signed [DW-1:0] ts_q;
	hds_pkg::hds_cell_t   in_q, held_q;
	logic signed [DW-1:0] s_r [4];
	logic signed [DW-1:0] d_r [4];
	logic signed [DW-1:0] h_r [4];
	logic signed [DW-1:0] pm_q, pn_q, mu_c_q, mv_c_q, mu_e_q;
	logic signed [DW-1:0] q_q, m_q, hs_q, sd_q, t_q;
	logic signed [63:0]   prod_q;
	logic signed [33:0]   acc_q;
	logic                 valid_q;

	logic [AW-1:0]        rd_addr, wr_addr;
	logic [CW-1:0]        col_m1, col_m2;
	logic [DW-1:0]        s_rd, d_rd, h_rd;
	logic [2*DW-1:0]      sp_rd, fm_rd;
	logic [DW-1:0]        s_wd, d_wd, h_wd;
	logic [2*DW-1:0]      sp_wd, fm_wd;
	logic [CW-1:0]        sp_waddr, fm_raddr;
	logic                 wr_en;
	logic signed [DW-1:0] da, db, ma, ha, hb, sa, sb, op_a, op_b, post_v;
	logic signed [33:0]   qsum;

	assign col_m1 = cmd.col - 1'b1;
	assign col_m2 = cmd.col - 2'd2;

	// line store addressing: previous row in the other slot, current row in this one
	always_comb begin
		unique case (cmd.rd_sel)
			2'd0:    rd_addr = {~cmd.par, col_m2};
			2'd1:    rd_addr = {~cmd.par, col_m1};
			2'd2:    rd_addr = {~cmd.par, cmd.col};
			default: rd_addr = {cmd.par, col_m1};
		endcase
		wr_en    = cmd.wr_held || cmd.wr_in;
		wr_addr  = cmd.wr_held ? {cmd.par, col_m1} : {cmd.par, cmd.col};
		sp_waddr = cmd.wr_held ? col_m1 : cmd.col;
		fm_raddr = (cmd.rd_sel == 2'd2) ? cmd.col : col_m1;
		s_wd  = cmd.wr_held ? held_q.tracer_value : in_q.tracer_value;
		d_wd  = cmd.wr_held ? held_q.diffusivity : in_q.diffusivity;
		h_wd  = cmd.wr_held ? held_q.layer_thickness : in_q.layer_thickness;
		sp_wd = cmd.wr_held ? {held_q.inv_dy, held_q.inv_dx} : {in_q.inv_dy, in_q.inv_dx};
		fm_wd = cmd.wr_held ? {held_q.v_face_metric, held_q.u_face_metric}
			: {in_q.v_face_metric, in_q.u_face_metric};
	end

	hds_ram #(.WIDTH(DW), .DEPTH(2*hds_pkg::MAX_WIDTH)) u_tracer (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(s_wd),
		.re(cmd.rd), .raddr(rd_addr), .rdata(s_rd));
	hds_ram #(.WIDTH(DW), .DEPTH(2*hds_pkg::MAX_WIDTH)) u_diff (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(d_wd),
		.re(cmd.rd), .raddr(rd_addr), .rdata(d_rd));
	hds_ram #(.WIDTH(DW), .DEPTH(2*hds_pkg::MAX_WIDTH)) u_thick (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(h_wd),
		.re(cmd.rd), .raddr(rd_addr), .rdata(h_rd));
	hds_ram #(.WIDTH(2*DW), .DEPTH(hds_pkg::MAX_WIDTH)) u_spacing (
		.clk(clk), .we(wr_en), .waddr(sp_waddr), .wdata(sp_wd),
		.re(cmd.rd), .raddr(col_m1), .rdata(sp_rd));
	hds_ram #(.WIDTH(2*DW), .DEPTH(hds_pkg::MAX_WIDTH)) u_metric (
		.clk(clk), .we(wr_en), .waddr(sp_waddr), .wdata(fm_wd),
		.re(cmd.rd), .raddr(fm_raddr), .rdata(fm_rd));

	// time step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ts_q <= '0;
		else if (cfg_wr.we && cfg_wr.index == hds_pkg::REG_TIME_STEP) ts_q <= cfg_wr.data;
	end

	// select the two cells of one face
	always_comb begin
		unique case (cmd.flux)
			2'd0: begin
				da = d_r[1]; db = d_r[0]; ma = mu_c_q;
				ha = h_r[1]; hb = h_r[0]; sa = s_r[1]; sb = s_r[0];
			end
			2'd1: begin
				da = d_r[2]; db = d_r[1]; ma = mu_e_q;
				ha = h_r[2]; hb = h_r[1]; sa = s_r[2]; sb = s_r[1];
			end
			2'd2: begin
				da = d_r[1]; db = d_r[3]; ma = mv_c_q;
				ha = h_r[1]; hb = h_r[3]; sa = s_r[1]; sb = s_r[3];
			end
			default: begin
				da = held_q.diffusivity; db = d_r[1]; ma = held_q.v_face_metric;
				ha = held_q.layer_thickness; hb = h_r[1];
				sa = held_q.tracer_value; sb = s_r[1];
			end
		endcase
		qsum = 34'(da) + 34'(db) + 34'sd2;
	end

	// multiplier operands
	always_comb begin
		unique case (cmd.src)
			hds_pkg::SRC_Q_M:   begin op_a = q_q;  op_b = m_q;  end
			hds_pkg::SRC_T_HS:  begin op_a = t_q;  op_b = hs_q; end
			hds_pkg::SRC_T_SD:  begin op_a = t_q;  op_b = sd_q; end
			hds_pkg::SRC_TS_PM: begin op_a = ts_q; op_b = pm_q; end
			hds_pkg::SRC_T_PN:  begin op_a = t_q;  op_b = pn_q; end
			default:            begin op_a = t_q;  op_b = hds_pkg::sat32(64'(acc_q)); end
		endcase
		post_v = hds_pkg::fx_post(prod_q);
	end

	// capture cell, neighbors, face terms and products
	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= grid_cell;
		if (cmd.shift) held_q <= in_q;
		if (cmd.cap) begin
			s_r[cmd.cap_sel] <= s_rd;
			d_r[cmd.cap_sel] <= d_rd;
			h_r[cmd.cap_sel] <= h_rd;
			if (cmd.cap_sel == 2'd1) begin
				pm_q   <= sp_rd[DW-1:0];
				pn_q   <= sp_rd[2*DW-1:DW];
				mu_c_q <= fm_rd[DW-1:0];
				mv_c_q <= fm_rd[2*DW-1:DW];
			end
			if (cmd.cap_sel == 2'd2) mu_e_q <= fm_rd[DW-1:0];
		end
		if (cmd.prep) begin
			q_q  <= DW'(qsum >>> 2);
			m_q  <= ma;
			hs_q <= hds_pkg::sat32(64'(ha) + 64'(hb));
			sd_q <= hds_pkg::sat32(64'(sa) - 64'(sb));
		end
		if (cmd.mul) prod_q <= op_a * op_b;
		if (cmd.post) t_q <= post_v;
		// east and north fluxes add, west and south subtract
		if (cmd.load) acc_q <= '0;
		else if (cmd.acc) acc_q <= cmd.flux[0] ? acc_q + 34'(post_v) : acc_q - 34'(post_v);
		if (cmd.fin) begin
			res_value <= hds_pkg::sat32(64'(s_r[1]) + 64'(t_q));
			res_done  <= cmd.done;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cmd.fin) valid_q <= 1'b1;
		else if (res_ready) valid_q <= 1'b0;
	end

	assign res_valid     = valid_q;
	assign stat.out_busy = valid_q && !res_ready;

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(cmd.fin)) else $error("result appeared without finish");
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench of harmonic_diffusion_stencil_top: streams planes of cells
// through the block, predicts every diffused interior cell and compares the results.
// Depends on hds_pkg, the three channel interfaces and the top module.
`timescale 1ns / 100ps
module tb;

	localparam int DRAIN = 64;        // cycles the block may still work after its last result
	localparam int WATCHDOG = 20000;  // cycles with no request moving on any channel
	localparam int HOLD_CYCLES = 3000;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [31:0] MAXV = 32'h7fffffff;
	localparam logic [31:0] MINV = 32'h80000000;
	localparam int MW = hds_pkg::MAX_WIDTH;

	typedef struct {
		logic [31:0] value;
		logic        done;
	} update_t;

	typedef struct {
		hds_pkg::hds_cell_t stim;
		bit                 has_exp;
		logic [31:0]        exp_value;
		logic               exp_done;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hds_cell_if   cell_ch ();
	hds_result_if res_ch ();
	hds_cfg_if    cfg_ch ();

	harmonic_diffusion_stencil_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.grid_cell (cell_ch),
		.result    (res_ch),
		.cfg       (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [9:0]         grid_w = 10'd512;
	logic [15:0]        grid_h = 16'd512;
	logic signed [31:0] dt = 0;
	int unsigned        col_cnt = 0, row_cnt = 0;
	logic signed [31:0] tr_line [2*MW];
	logic signed [31:0] df_line [2*MW];
	logic signed [31:0] th_line [2*MW];
	logic signed [31:0] pm_line [MW];
	logic signed [31:0] pn_line [MW];
	logic signed [31:0] mu_line [MW];
	logic signed [31:0] mv_line [MW];
	hds_pkg::hds_cell_t held = '0;

	update_t pending_updates [$];
	int errors = 0, cells_sent = 0, updates_seen = 0, cfg_writes = 0, planes_done = 0;
	int idle_pct = 0, stall_pct = 0;
	bit long_hold_req = 0;
	int hold_left = 0;
	int quiet = 0;

	// typed expectation travels with the cell request
	bit          typed_en = 0;
	logic [31:0] typed_value = '0;
	logic        typed_done = 0;

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fx(longint a, longint b);
		longint p;
		p = a * b + ((longint'(1) << hds_pkg::FRAC_BITS) >>> 1);
		return sat(p >>> hds_pkg::FRAC_BITS);
	endfunction

	function automatic longint face_flux(longint da, longint db, longint m,
			longint ha, longint hb, longint sa, longint sb);
		longint q, t;
		q = (da + db + 2) >>> 2;
		t = fx(q, m);
		t = fx(t, sat(ha + hb));
		return fx(t, sat(sa - sb));
	endfunction

	// store a cell in both the line slot and the metric lines
	function automatic void store_cell(int unsigned slot, int unsigned c,
			hds_pkg::hds_cell_t x);
		tr_line[slot + c] = x.tracer_value;
		df_line[slot + c] = x.diffusivity;
		th_line[slot + c] = x.layer_thickness;
		pm_line[c] = x.inv_dx;
		pn_line[c] = x.inv_dy;
		mu_line[c] = x.u_face_metric;
		mv_line[c] = x.v_face_metric;
	endfunction

	// advance the stencil by one cell; returns 1 and the update when one is released
	function automatic bit diffuse_cell(hds_pkg::hds_cell_t x, output update_t u);
		int unsigned w, h, c, r, cur, prv, i;
		longint fxw, fxe, fes, fen, dv, k;
		bit got;
		got = 0;
		u = '{default: '0};
		w = (grid_w < 3) ? 3 : ((grid_w > MW) ? MW : grid_w);
		h = (grid_h < 3) ? 3 : grid_h;
		c = col_cnt;
		r = row_cnt;
		cur = (r & 1) * MW;
		prv = ((r + 1) & 1) * MW;
		if (c >= w) c = w - 1;
		if (c >= 1) begin
			if (r >= 2 && c >= 2) begin
				i = c - 1;
				fxw = face_flux(df_line[prv+i], df_line[prv+i-1], mu_line[i],
					th_line[prv+i], th_line[prv+i-1], tr_line[prv+i], tr_line[prv+i-1]);
				fxe = face_flux(df_line[prv+c], df_line[prv+i], mu_line[c],
					th_line[prv+c], th_line[prv+i], tr_line[prv+c], tr_line[prv+i]);
				fes = face_flux(df_line[prv+i], df_line[cur+i], mv_line[i],
					th_line[prv+i], th_line[cur+i], tr_line[prv+i], tr_line[cur+i]);
				fen = face_flux(held.diffusivity, df_line[prv+i], held.v_face_metric,
					held.layer_thickness, th_line[prv+i], held.tracer_value, tr_line[prv+i]);
				dv = sat((fxe - fxw) + (fen - fes));
				k = fx(fx(dt, pm_line[i]), pn_line[i]);
				u.value = 32'(sat(longint'(tr_line[prv+i]) + fx(k, dv)));
				u.done = (r == h - 1) && (c == w - 1);
				got = 1;
			end
			store_cell(cur, c - 1, held);
		end
		held = x;
		if (c >= w - 1) begin
			store_cell(cur, c, x);
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
		return got;
	endfunction

	// predict on every accepted cell, track register writes
	always @(posedge clk) begin
		hds_pkg::hds_cell_t x;
		update_t u;
		bit got;
		if (cell_ch.valid && cell_ch.ready) begin
			x.tracer_value    = cell_ch.tracer_value;
			x.diffusivity     = cell_ch.diffusivity;
			x.layer_thickness = cell_ch.layer_thickness;
			x.inv_dx          = cell_ch.inv_dx;
			x.inv_dy          = cell_ch.inv_dy;
			x.u_face_metric   = cell_ch.u_face_metric;
			x.v_face_metric   = cell_ch.v_face_metric;
			got = diffuse_cell(x, u);
			if (typed_en) begin
				u.value = typed_value;
				u.done = typed_done;
			end
			if (got || typed_en) pending_updates.push_back(u);
		end
		if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.reg_index)
				hds_pkg::REG_GRID_WIDTH: begin
					grid_w = cfg_ch.wr_data[9:0];
					col_cnt = 0;
					row_cnt = 0;
				end
				hds_pkg::REG_GRID_HEIGHT: begin
					grid_h = cfg_ch.wr_data[15:0];
					col_cnt = 0;
					row_cnt = 0;
				end
				hds_pkg::REG_TIME_STEP: dt = cfg_ch.wr_data;
				default: ;
			endcase
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		update_t u;
		if (res_ch.valid && res_ch.ready) begin
			updates_seen++;
			if (pending_updates.size() == 0) begin
				$error("unexpected update: updated_value %h plane_done %b",
					res_ch.updated_value, res_ch.plane_done);
				errors++;
			end else begin
				u = pending_updates.pop_front();
				if (res_ch.updated_value !== u.value) begin
					$error("updated_value: expected %h, got %h", u.value, res_ch.updated_value);
					errors++;
				end
				if (res_ch.plane_done !== u.done) begin
					$error("plane_done: expected %b, got %b", u.done, res_ch.plane_done);
					errors++;
				end
				if (res_ch.plane_done === 1'b1) planes_done++;
			end
		end
	end

	// result sink: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 0;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles where no request moves
	always @(posedge clk) begin
		if ((cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || !arst_n) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic put_cell(hds_pkg::hds_cell_t x, bit te = 0, logic [31:0] tv = '0,
			logic td = 0);
		while ($urandom_range(99) < idle_pct) begin
			cell_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cell_ch.valid           <= 1'b1;
		cell_ch.tracer_value    <= x.tracer_value;
		cell_ch.diffusivity     <= x.diffusivity;
		cell_ch.layer_thickness <= x.layer_thickness;
		cell_ch.inv_dx          <= x.inv_dx;
		cell_ch.inv_dy          <= x.inv_dy;
		cell_ch.u_face_metric   <= x.u_face_metric;
		cell_ch.v_face_metric   <= x.v_face_metric;
		typed_en    <= te;
		typed_value <= tv;
		typed_done  <= td;
		@(posedge clk);
		while (!cell_ch.ready) @(posedge clk);
		cells_sent++;
	endtask

	// drop valid after the last cell of a phase
	task automatic end_cells();
		cell_ch.valid <= 1'b0;
		typed_en <= 0;
		@(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data   <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_writes++;
		@(posedge clk);
	endtask

	// wait until every predicted update is out and the block has gone quiet
	task automatic settle();
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_field(bit wide);
		if (wide) return $urandom;
		return $urandom_range(32'h80000) - 32'h40000;
	endfunction

	function automatic hds_pkg::hds_cell_t rand_cell();
		hds_pkg::hds_cell_t x;
		bit wide;
		wide = ($urandom_range(9) < 2);
		x.tracer_value    = rand_field(wide);
		x.diffusivity     = rand_field(wide);
		x.layer_thickness = rand_field(wide);
		x.inv_dx          = rand_field(wide);
		x.inv_dy          = rand_field(wide);
		x.u_face_metric   = rand_field(wide);
		x.v_face_metric   = rand_field(wide);
		return x;
	endfunction

	stim_row_t dir_rows [25];

	initial begin
		int n_items, ph, w, h;
		logic [31:0] v;
		cell_ch.valid = 1'b0;
		cell_ch.tracer_value = '0;
		cell_ch.diffusivity = '0;
		cell_ch.layer_thickness = '0;
		cell_ch.inv_dx = '0;
		cell_ch.inv_dy = '0;
		cell_ch.u_face_metric = '0;
		cell_ch.v_face_metric = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = '0;
		cfg_ch.wr_data = '0;
		res_ch.ready = 1'b0;

		// directed table: a 3x3 plane at the reset time step, then a 4x4 plane of extremes
		for (int k = 0; k < 25; k++) begin
			v = (k % 3 == 0) ? MAXV : ((k % 3 == 1) ? MINV : 32'(k) << 16);
			dir_rows[k].stim = '{v, ~v, v ^ 32'h5555_5555, v, ~v, 32'h0001_0000, v};
			dir_rows[k].has_exp = 0;
			dir_rows[k].exp_value = '0;
			dir_rows[k].exp_done = 0;
		end
		// time step zero leaves the center cell untouched
		dir_rows[4].stim.tracer_value = MAXV;
		dir_rows[8].has_exp = 1;
		dir_rows[8].exp_value = MAXV;
		dir_rows[8].exp_done = 1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown index must change nothing
		cfg_write(REG_UNUSED, 32'h0000_0004);
		cfg_write(hds_pkg::REG_GRID_WIDTH, 32'd3);
		cfg_write(hds_pkg::REG_GRID_HEIGHT, 32'd3);
		for (int k = 0; k < 25; k++) begin
			if (k == 9) begin
				end_cells();
				settle();
				cfg_write(hds_pkg::REG_GRID_WIDTH, 32'd4);
				cfg_write(hds_pkg::REG_GRID_HEIGHT, 32'd4);
				cfg_write(hds_pkg::REG_TIME_STEP, MAXV);
			end
			put_cell(dir_rows[k].stim, dir_rows[k].has_exp, dir_rows[k].exp_value,
				dir_rows[k].exp_done);
		end
		end_cells();

		// random phases over geometries, time steps and idling
		ph = 0;
		while (cells_sent < 850 || ph < 6) begin
			settle();
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 53; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 53; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			w = $urandom_range(3, 12);
			h = $urandom_range(3, 8);
			n_items = w * h * $urandom_range(1, 2);
			if ($urandom_range(3) == 0) n_items = n_items - $urandom_range(1, w);
			case (ph)
				1: begin
					// width beyond the line store clamps to its size: one full row and a few cells
					cfg_write(hds_pkg::REG_GRID_WIDTH, 32'd1023);
					h = 3;
					n_items = MW + 8;
				end
				2: begin
					// tallest plane, abandoned part way by the next geometry write
					h = 65535;
					n_items = w * 4 + 2;
				end
				3: begin
					idle_pct = 0;
					stall_pct = 0;
					w = 8;
					h = 6;
					n_items = 48;
					long_hold_req = 1;
				end
				5: begin
					// too small in both directions: becomes 3x3
					cfg_write(hds_pkg::REG_GRID_WIDTH, $urandom_range(2));
					h = $urandom_range(2);
					n_items = 18;
				end
				default: ;
			endcase
			if (ph != 1 && ph != 5) cfg_write(hds_pkg::REG_GRID_WIDTH, 32'(w));
			cfg_write(hds_pkg::REG_GRID_HEIGHT, 32'(h));
			case (ph % 5)
				0: cfg_write(hds_pkg::REG_TIME_STEP, MINV);
				1: cfg_write(hds_pkg::REG_TIME_STEP, 32'h0000_0001);
				2: cfg_write(hds_pkg::REG_TIME_STEP, 32'h0000_0000);
				3: cfg_write(hds_pkg::REG_TIME_STEP, $urandom);
				default: cfg_write(hds_pkg::REG_TIME_STEP, $urandom_range(32'h40000) - 32'h20000);
			endcase
			for (int k = 0; k < n_items; k++) put_cell(rand_cell());
			end_cells();
			ph++;
		end

		idle_pct = 0;
		stall_pct = 0;
		settle();
		$display("Sent %0d cells in %0d phases with %0d register writes;", cells_sent,
			ph + 2, cfg_writes);
		$display("checked %0d diffused cells, %0d of them closing a plane.", updates_seen,
			planes_done);
		if (errors == 0 && pending_updates.size() == 0) begin
			$display("All tests passed");
		end else begin
			if (pending_updates.size() != 0)
				$error("%0d predicted updates never arrived", pending_updates.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
